/* hdl/fba_pkg.sv */
package fba_pkg;

  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int REQ_W  = 16;
  localparam int FREE_W = 16;
  localparam int FRAG_W = 20;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 5;

  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IW-1:0] REG_POLICY      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_BLOCK_COUNT = 2'd1;

  localparam logic [CFG_DW-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] block_index;
    logic [REQ_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  chosen_index;
    logic [FREE_W-1:0] block_free;
    logic [FREE_W-1:0] block_used;
    logic [FRAG_W-1:0] fragmentation;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD_WR,
    ST_STATUS,
    ST_SCAN,
    ST_UPD_SUB,
    ST_UPD_ADD,
    ST_FINISH
  } state_t;

endpackage

/* hdl/fit_block_allocator.sv */
// Fixed-partition allocator with first, best and worst fit placement. Each
// partition keeps its original and remaining size in one single-port-read RAM;
// a valid bit per entry makes unwritten partitions read as zero, so there is
// no clearing pass after reset. An allocate scans partitions 0 .. min(block_count,
// BLOCKS)-1 one RAM read per cycle through one comparator and then, when a
// partition is granted, updates the chosen entry and the fragmentation total.
// req_stall is high while a word is being worked on; a finished result waits
// in the output register and does not block the next word from being taken,
// but a second result that finishes while that register is still stalled
// holds req_stall high until it drains. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while idle, as
// the block itself does not enforce this.
module fit_block_allocator #(
  parameter int BLOCKS    = fba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fba_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fba_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  fba_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output fba_pkg::rsp_t              rsp
);

  import fba_pkg::*;

  localparam int IW   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW   = $clog2(BLOCKS + 1);
  localparam int LW   = (CW > CFG_DW) ? CW : CFG_DW;
  localparam int XW   = (IW > IDX_W) ? IW : IDX_W;
  localparam int OW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int CMPW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int FW   = SIZE_BITS + CW;
  localparam int FXW  = (FW > FRAG_W) ? FW : FRAG_W;

  localparam logic [CMPW-1:0] SIZE_MAX = CMPW'({SIZE_BITS{1'b1}});
  localparam logic [LW-1:0]   BLK_LIM  = LW'(BLOCKS);
  localparam logic [OW-1:0]   BLK_OW   = OW'(BLOCKS);
  localparam logic [FXW-1:0]  FRAG_SAT = FXW'({FRAG_W{1'b1}});

  state_t state, state_next;

  logic [1:0]           policy;
  logic [CFG_DW-1:0]    block_count;

  logic [OP_W-1:0]      op_q, op_next;
  logic [IDX_W-1:0]     bi_q, bi_next;
  logic [REQ_W-1:0]     sz_q, sz_next;

  logic [CW-1:0]        iss, iss_next;
  logic                 cmp_v, cmp_v_next;
  logic [IW-1:0]        cmp_idx, cmp_idx_next;
  logic                 found, found_next;
  logic [IW-1:0]        pick, pick_next;
  logic [SIZE_BITS-1:0] pick_orig, pick_orig_next;
  logic [SIZE_BITS-1:0] pick_rem, pick_rem_next;
  logic [FW-1:0]        frag, frag_next;

  logic                 res_granted, res_granted_next;
  logic [IDX_W-1:0]     res_idx, res_idx_next;
  logic [SIZE_BITS-1:0] res_free, res_free_next;
  logic [SIZE_BITS-1:0] res_used, res_used_next;

  logic                 rsp_valid_next;
  rsp_t                 rsp_next;

  logic [BLOCKS-1:0]    valid;
  logic                 vld_q;

  logic                     ram_we, ram_re;
  logic [IW-1:0]            ram_waddr, ram_raddr;
  logic [2*SIZE_BITS-1:0]   ram_wdata, ram_rdata;

  logic [SIZE_BITS-1:0] rd_orig, rd_rem, new_rem, load_val;
  logic [CMPW-1:0]      rem_ext, sz_ext, pick_rem_ext;
  logic [LW-1:0]        limit, bc_ext;
  logic [XW-1:0]        bi_x, pick_x;
  logic [FXW-1:0]       frag_ext;
  logic                 accept, fits, better, out_of_range;

  fba_ram #(
    .WIDTH (2 * SIZE_BITS),
    .DEPTH (BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  assign rd_orig = vld_q ? ram_rdata[2*SIZE_BITS-1:SIZE_BITS] : '0;
  assign rd_rem  = vld_q ? ram_rdata[SIZE_BITS-1:0] : '0;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign sz_ext       = CMPW'(sz_q);
  assign rem_ext      = CMPW'(rd_rem);
  assign pick_rem_ext = CMPW'(pick_rem);
  assign load_val     = (sz_ext > SIZE_MAX) ? SIZE_MAX[SIZE_BITS-1:0] : sz_ext[SIZE_BITS-1:0];
  assign new_rem      = SIZE_BITS'(pick_rem_ext - sz_ext);

  assign bc_ext = LW'(block_count);
  assign limit  = (bc_ext > BLK_LIM) ? BLK_LIM : bc_ext;

  assign bi_x         = XW'(bi_q);
  assign pick_x       = XW'(pick);
  assign out_of_range = (OW'(req.block_index) >= BLK_OW);

  assign fits   = (rem_ext >= sz_ext);
  assign better = !found
               || ((policy == POL_BEST) && (rem_ext < pick_rem_ext))
               || ((policy == POL_WORST) && (rem_ext > pick_rem_ext));

  assign frag_ext = FXW'(frag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      policy      <= POL_FIRST;
      block_count <= BLOCK_COUNT_RST;
      cmp_v       <= 1'b0;
      found       <= 1'b0;
      frag        <= '0;
      rsp_valid   <= 1'b0;
      valid       <= '0;
      vld_q       <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_v     <= cmp_v_next;
      found     <= found_next;
      frag      <= frag_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:      policy <= cfg_data[1:0];
          REG_BLOCK_COUNT: block_count <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_q <= valid[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q        <= op_next;
    bi_q        <= bi_next;
    sz_q        <= sz_next;
    iss         <= iss_next;
    cmp_idx     <= cmp_idx_next;
    pick        <= pick_next;
    pick_orig   <= pick_orig_next;
    pick_rem    <= pick_rem_next;
    res_granted <= res_granted_next;
    res_idx     <= res_idx_next;
    res_free    <= res_free_next;
    res_used    <= res_used_next;
    rsp         <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    op_next          = op_q;
    bi_next          = bi_q;
    sz_next          = sz_q;
    iss_next         = iss;
    cmp_v_next       = cmp_v;
    cmp_idx_next     = cmp_idx;
    found_next       = found;
    pick_next        = pick;
    pick_orig_next   = pick_orig;
    pick_rem_next    = pick_rem;
    frag_next        = frag;
    res_granted_next = res_granted;
    res_idx_next     = res_idx;
    res_free_next    = res_free;
    res_used_next    = res_used;
    rsp_valid_next   = rsp_valid && rsp_stall;
    rsp_next         = rsp;
    ram_we           = 1'b0;
    ram_waddr        = pick;
    ram_wdata        = {pick_orig, pick_rem};
    ram_re           = 1'b0;
    ram_raddr        = bi_x[IW-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next          = req.operation;
          bi_next          = req.block_index;
          sz_next          = req.size;
          iss_next         = '0;
          cmp_v_next       = 1'b0;
          found_next       = 1'b0;
          pick_next        = '0;
          res_granted_next = 1'b0;
          res_idx_next     = '0;
          res_free_next    = '0;
          res_used_next    = '0;
          case (req.operation)
            OP_LOAD, OP_READ: begin
              if (out_of_range) begin
                res_idx_next = req.block_index;
                state_next   = ST_FINISH;
              end else begin
                state_next = ST_READ;
              end
            end
            OP_ALLOCATE: state_next = ST_SCAN;
            default:     state_next = ST_FINISH;
          endcase
        end
      end

      ST_READ: begin
        ram_re     = 1'b1;
        state_next = (op_q == OP_LOAD) ? ST_LOAD_WR : ST_STATUS;
      end

      ST_LOAD_WR: begin
        if (rd_orig != rd_rem) begin
          frag_next = frag - FW'(rd_rem);
        end
        ram_we           = 1'b1;
        ram_waddr        = bi_x[IW-1:0];
        ram_wdata        = {load_val, load_val};
        res_granted_next = 1'b1;
        res_idx_next     = bi_q;
        res_free_next    = load_val;
        res_used_next    = '0;
        state_next       = ST_FINISH;
      end

      ST_STATUS: begin
        res_granted_next = 1'b1;
        res_idx_next     = bi_q;
        res_free_next    = rd_rem;
        res_used_next    = rd_orig - rd_rem;
        state_next       = ST_FINISH;
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the word read the cycle before
        if (LW'(iss) < limit) begin
          ram_re       = 1'b1;
          ram_raddr    = iss[IW-1:0];
          cmp_idx_next = iss[IW-1:0];
          iss_next     = iss + CW'(1);
          cmp_v_next   = 1'b1;
        end else begin
          cmp_v_next = 1'b0;
        end
        if (cmp_v && fits && better) begin
          found_next     = 1'b1;
          pick_next      = cmp_idx;
          pick_orig_next = rd_orig;
          pick_rem_next  = rd_rem;
        end
        if (!(LW'(iss) < limit) && !cmp_v) begin
          state_next = found ? ST_UPD_SUB : ST_FINISH;
        end
      end

      ST_UPD_SUB: begin
        if (pick_orig != pick_rem) begin
          frag_next = frag - FW'(pick_rem);
        end
        ram_we        = 1'b1;
        ram_waddr     = pick;
        ram_wdata     = {pick_orig, new_rem};
        pick_rem_next = new_rem;
        state_next    = ST_UPD_ADD;
      end

      ST_UPD_ADD: begin
        if (pick_orig != pick_rem) begin
          frag_next = frag + FW'(pick_rem);
        end
        res_granted_next = 1'b1;
        res_idx_next     = pick_x[IDX_W-1:0];
        res_free_next    = pick_rem;
        res_used_next    = pick_orig - pick_rem;
        state_next       = ST_FINISH;
      end

      ST_FINISH: begin
        // wait for the output register to free up
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next         = 1'b1;
          rsp_next.granted       = res_granted;
          rsp_next.chosen_index  = res_idx;
          rsp_next.block_free    = FREE_W'(CMPW'(res_free));
          rsp_next.block_used    = FREE_W'(CMPW'(res_used));
          rsp_next.fragmentation = (frag_ext > FRAG_SAT) ? FRAG_SAT[FRAG_W-1:0]
                                                         : frag_ext[FRAG_W-1:0];
          state_next             = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/fba_ram.sv */
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fba_pkg::*;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
  localparam logic [1:0]        POL_SPARE = 2'd3;
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 50;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;

  fit_block_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // partition table as the block should hold it
  logic [REQ_W-1:0] part_orig [BLOCKS_DEF];
  logic [REQ_W-1:0] part_left [BLOCKS_DEF];
  int               frag_sum = 0;
  logic [1:0]       cur_policy = POL_FIRST;
  logic [CFG_DW-1:0] cur_count = BLOCK_COUNT_RST;

  rsp_t pending_rsp[$];
  int   mismatch_count = 0;
  int   burst_left = 0;
  int   hold_requests = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;

  initial begin
    for (int k = 0; k < BLOCKS_DEF; k++) begin
      part_orig[k] = '0;
      part_left[k] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected result of one word; updates the table
  function automatic rsp_t fit_outcome(req_t w);
    rsp_t r;
    int   k;
    int   lim;
    bit   hit;
    int   pick;
    r = '0;
    case (w.operation)
      OP_LOAD, OP_READ: begin
        k = int'(w.block_index);
        if (w.operation == OP_LOAD) begin
          if (part_orig[k] != part_left[k]) frag_sum -= int'(part_left[k]);
          part_orig[k] = w.size;
          part_left[k] = w.size;
        end
        r.granted = 1'b1;
        r.chosen_index = w.block_index;
        r.block_free = part_left[k];
        r.block_used = part_orig[k] - part_left[k];
      end
      OP_ALLOCATE: begin
        lim = (cur_count > BLOCKS_DEF) ? BLOCKS_DEF : int'(cur_count);
        hit = 1'b0;
        pick = 0;
        for (int j = 0; j < lim; j++) begin
          if (part_left[j] >= w.size) begin
            if (!hit) begin
              hit = 1'b1;
              pick = j;
            end else if (cur_policy == POL_BEST && part_left[j] < part_left[pick]) begin
              pick = j;
            end else if (cur_policy == POL_WORST && part_left[j] > part_left[pick]) begin
              pick = j;
            end
          end
        end
        if (hit) begin
          if (part_orig[pick] != part_left[pick]) frag_sum -= int'(part_left[pick]);
          part_left[pick] = part_left[pick] - w.size;
          if (part_orig[pick] != part_left[pick]) frag_sum += int'(part_left[pick]);
          r.granted = 1'b1;
          r.chosen_index = pick[IDX_W-1:0];
          r.block_free = part_left[pick];
          r.block_used = part_orig[pick] - part_left[pick];
        end
      end
      default: begin
      end
    endcase
    r.fragmentation = (frag_sum > 'hFFFFF) ? 20'hFFFFF : frag_sum[FRAG_W-1:0];
    return r;
  endfunction

  function automatic req_t make_word(logic [OP_W-1:0] op, int idx, int sz);
    req_t w;
    w.operation = op;
    w.block_index = idx[IDX_W-1:0];
    w.size = sz[REQ_W-1:0];
    return w;
  endfunction

  function automatic req_t random_word();
    int sel;
    int pick;
    int idx;
    int sz;
    sel = $urandom_range(0, 99);
    idx = $urandom_range(0, BLOCKS_DEF - 1);
    pick = $urandom_range(0, 99);
    if (sel < 25) begin
      if (pick < 60) sz = $urandom_range(0, 4095);
      else if (pick < 85) sz = $urandom_range(0, 65535);
      else if (pick < 90) sz = 0;
      else sz = 65535;
      return make_word(OP_LOAD, idx, sz);
    end else if (sel < 75) begin
      if (pick < 40) sz = $urandom_range(0, 255);
      else if (pick < 65) sz = $urandom_range(0, 4095);
      else if (pick < 85) sz = int'(part_left[$urandom_range(0, BLOCKS_DEF - 1)]);
      else if (pick < 95) sz = $urandom_range(0, 65535);
      else sz = 0;
      return make_word(OP_ALLOCATE, idx, sz);
    end else if (sel < 95) begin
      return make_word(OP_READ, idx, $urandom_range(0, 65535));
    end
    return make_word(OP_NONE, idx, $urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, logic [FRAG_W-1:0] got,
                                 logic [FRAG_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [FRAG_W-1:0] got, logic [FRAG_W-1:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // sender: bursts of words with idle gaps between them
  task automatic send_word(req_t w);
    int gap;
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(fit_outcome(w));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLICY) cur_policy = d[1:0];
    else if (idx == REG_BLOCK_COUNT) cur_count = d;
    @(posedge clk);
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result word with none pending", rsp.fragmentation, '0);
      end else begin
        want = pending_rsp.pop_front();
        check_field("granted", FRAG_W'(rsp.granted), FRAG_W'(want.granted));
        check_field("chosen_index", FRAG_W'(rsp.chosen_index), FRAG_W'(want.chosen_index));
        check_field("block_free", FRAG_W'(rsp.block_free), FRAG_W'(want.block_free));
        check_field("block_used", FRAG_W'(rsp.block_used), FRAG_W'(want.block_used));
        check_field("fragmentation", rsp.fragmentation, want.fragmentation);
      end
    end
  end

  task automatic test_after_reset();
    send_word(make_word(OP_READ, 0, 0));
    send_word(make_word(OP_READ, 15, 'hFFFF));
    send_word(make_word(OP_ALLOCATE, 0, 0));
    send_word(make_word(OP_ALLOCATE, 0, 1));
    send_word(make_word(OP_NONE, 15, 'hFFFF));
  endtask

  task automatic test_fit_policies();
    send_word(make_word(OP_LOAD, 0, 100));
    send_word(make_word(OP_LOAD, 1, 50));
    send_word(make_word(OP_LOAD, 2, 200));
    send_word(make_word(OP_LOAD, 3, 50));
    send_word(make_word(OP_LOAD, 15, 'hFFFF));
    send_word(make_word(OP_ALLOCATE, 0, 60));
    send_word(make_word(OP_ALLOCATE, 0, 'hFFFF));
    wait_idle();
    write_cfg(REG_POLICY, {3'b000, POL_BEST});
    send_word(make_word(OP_ALLOCATE, 0, 50));
    wait_idle();
    write_cfg(REG_POLICY, {3'b000, POL_WORST});
    send_word(make_word(OP_ALLOCATE, 0, 10));
    send_word(make_word(OP_READ, 2, 0));
    send_word(make_word(OP_READ, 15, 0));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_cfg(REG_POLICY, {3'b111, POL_SPARE});
    send_word(make_word(OP_ALLOCATE, 0, 10));
    wait_idle();
    write_cfg(REG_BLOCK_COUNT, 5'd0);
    send_word(make_word(OP_ALLOCATE, 0, 0));
    wait_idle();
    write_cfg(REG_BLOCK_COUNT, 5'd31);
    send_word(make_word(OP_ALLOCATE, 0, 1));
    wait_idle();
    write_cfg(REG_BLOCK_COUNT, 5'd1);
    send_word(make_word(OP_ALLOCATE, 0, 100));
    wait_idle();
    write_cfg(REG_SPARE, 5'b10101);
    write_cfg(REG_BLOCK_COUNT, BLOCK_COUNT_RST);
    write_cfg(REG_POLICY, {3'b000, POL_FIRST});
    send_word(make_word(OP_LOAD, 0, 0));
    send_word(make_word(OP_READ, 0, 0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int n;
    logic [CFG_DW-1:0] cnt;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: cnt = 5'd1;
        1: cnt = 5'd16;
        2: cnt = 5'd0;
        3: cnt = 5'd31;
        default: cnt = (p % 2) ? CFG_DW'($urandom_range(1, 16))
                               : CFG_DW'($urandom_range(0, 31));
      endcase
      write_cfg(REG_POLICY, {3'($urandom_range(0, 7)), 2'(p % 4)});
      write_cfg(REG_BLOCK_COUNT, cnt);
      n = 0;
      while (n < ((cnt == 0) ? 20 : 60)) begin
        req_t w;
        w = random_word();
        send_word(w);
        if (w.operation != OP_NONE) n++;
      end
      wait_idle();
    end
  endtask

  // results held back long enough that the block backs up its input
  task automatic test_backpressure();
    write_cfg(REG_POLICY, {3'b000, POL_BEST});
    write_cfg(REG_BLOCK_COUNT, BLOCK_COUNT_RST);
    hold_requests++;
    for (int i = 0; i < 40; i++) send_word(random_word());
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_POLICY;
    cfg_data <= '0;
    req_valid <= 1'b0;
    req <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_fit_policies();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/fba_pkg.sv
hdl/fba_ram.sv
hdl/fit_block_allocator.sv
verif/tb_top.sv
